// ===== src/teq_pkg.sv =====
// ----------------------------------------------------------------------------
// teq_pkg
// shared constants, codes and control types of the timed event queue
// ----------------------------------------------------------------------------
package teq_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = 9;

   localparam int TIME_W    = 32;
   localparam int HANDLER_W = 8;
   localparam int PAYLOAD_W = 56;
   localparam int SLOT_W    = 8;
   localparam int ENTRY_W   = TIME_W + HANDLER_W + PAYLOAD_W;

   // command codes
   localparam logic [1:0] CMD_SCHEDULE = 2'd0;
   localparam logic [1:0] CMD_CANCEL   = 2'd1;
   localparam logic [1:0] CMD_POP      = 2'd2;

   // status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_EMPTY   = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic latch;
      logic scan_read;
      logic fetch;
      logic commit;
   } teq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] command;
      logic       used_zero;
      logic       scan_last;
   } teq_sts_type;

endpackage

// ===== src/timed_event_queue_with_cancel_top.sv =====
// schedule, cancel and a pop on a table with no used slots go from acceptance straight to the result state
// a pop over a non-empty table reads each used slot once, then passes a drain state and the winner fetch
// throughput: one command in flight; the next req beat is taken once the result is registered
// the result register lets a new command start while the previous result beat waits
// reset: synchronous, active high; clears used count, dead flags, sequencer and rsp_valid
// ----------------------------------------------------------------------------
// timed_event_queue_with_cancel_top
// table of timed events with schedule, cancel by slot and pop of the earliest
// live event; ties go to the lower slot, slots are never reused
// ----------------------------------------------------------------------------
module timed_event_queue_with_cancel_top (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_command,
   input  logic [teq_pkg::TIME_W-1:0]         req_event_time,
   input  logic [teq_pkg::HANDLER_W-1:0]      req_handler_id,
   input  logic [teq_pkg::PAYLOAD_W-1:0]      req_payload,
   input  logic [teq_pkg::SLOT_W-1:0]         req_token,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [teq_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [teq_pkg::TIME_W-1:0]         rsp_fire_time,
   output logic [teq_pkg::HANDLER_W-1:0]      rsp_fire_handler,
   output logic [teq_pkg::PAYLOAD_W-1:0]      rsp_fire_payload
);

   // sequencer commands and datapath status
   teq_pkg::teq_cmd_type cmd;
   teq_pkg::teq_sts_type sts;

   // sequencer: idle, slot scan, last compare, winner fetch, result hand-off
   teq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: event ram, dead flags, running minimum and result register
   teq_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_event_time   (req_event_time),
      .req_handler_id   (req_handler_id),
      .req_payload      (req_payload),
      .req_token        (req_token),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_fire_time    (rsp_fire_time),
      .rsp_fire_handler (rsp_fire_handler),
      .rsp_fire_payload (rsp_fire_payload)
   );

endmodule

// ===== src/teq_ram.sv =====
// ----------------------------------------------------------------------------
// teq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module teq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/teq_ctrl.sv =====
// ----------------------------------------------------------------------------
// teq_ctrl
// command sequencer: accept, slot scan, winner fetch and result hand-off
// ----------------------------------------------------------------------------
module teq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  teq_pkg::teq_sts_type sts,
   output teq_pkg::teq_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_FETCH  = 3'd3;
   localparam logic [2:0] S_RESULT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cmd.latch     = 1'b0;
      cmd.scan_read = 1'b0;
      cmd.fetch     = 1'b0;
      cmd.commit    = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               state_in  = S_RESULT;
            end
         end
         S_SCAN: begin
            cmd.scan_read = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FETCH;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // a pop over a non-empty table walks the slots first
      if (accept && (sts.command == teq_pkg::CMD_POP) && !sts.used_zero) begin
         state_in = S_SCAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/teq_dp.sv =====
// ----------------------------------------------------------------------------
// teq_dp
// event table, live flags, minimum search and result register
// ----------------------------------------------------------------------------
module teq_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [1:0]                         req_command,
   input  logic [teq_pkg::TIME_W-1:0]         req_event_time,
   input  logic [teq_pkg::HANDLER_W-1:0]      req_handler_id,
   input  logic [teq_pkg::PAYLOAD_W-1:0]      req_payload,
   input  logic [teq_pkg::SLOT_W-1:0]         req_token,
   input  teq_pkg::teq_cmd_type               cmd,
   output teq_pkg::teq_sts_type               sts,
   output logic [1:0]                         rsp_status,
   output logic [teq_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [teq_pkg::TIME_W-1:0]         rsp_fire_time,
   output logic [teq_pkg::HANDLER_W-1:0]      rsp_fire_handler,
   output logic [teq_pkg::PAYLOAD_W-1:0]      rsp_fire_payload
);

   localparam int IDX_W = teq_pkg::IDX_W;
   localparam int CNT_W = teq_pkg::CNT_W;
   localparam int EW    = teq_pkg::ENTRY_W;

   // latched request
   logic [1:0]                    cmd_ff;
   logic [teq_pkg::TIME_W-1:0]    time_ff;
   logic [teq_pkg::HANDLER_W-1:0] handler_ff;
   logic [teq_pkg::PAYLOAD_W-1:0] payload_ff;
   logic [teq_pkg::SLOT_W-1:0]    token_ff;

   // table control
   logic [CNT_W-1:0]              used_ff;
   logic [teq_pkg::CAPACITY-1:0]  dead_ff;

   // scan
   logic [IDX_W-1:0]              scan_idx_ff;
   logic                          scan_vld_ff;
   logic [IDX_W-1:0]              rd_idx_ff;
   logic                          found_ff;
   logic [IDX_W-1:0]              best_ff;
   logic [teq_pkg::TIME_W-1:0]    best_time_ff;

   // result register
   logic [1:0]                    status_ff;
   logic [teq_pkg::SLOT_W-1:0]    slot_ff;
   logic [teq_pkg::TIME_W-1:0]    fire_time_ff;
   logic [teq_pkg::HANDLER_W-1:0] fire_handler_ff;
   logic [teq_pkg::PAYLOAD_W-1:0] fire_payload_ff;

   logic                          full;
   logic                          sched_ok;
   logic                          cancel_ok;
   logic                          pop_ok;
   logic [1:0]                    status_in;
   logic [teq_pkg::SLOT_W-1:0]    slot_in;
   logic                          ram_wr;
   logic                          ram_rd;
   logic [IDX_W-1:0]              ram_raddr;
   logic [EW-1:0]                 ram_rdata;
   logic [teq_pkg::TIME_W-1:0]    rd_time;
   logic                          take;

   assign full      = (used_ff == CNT_W'(teq_pkg::CAPACITY));
   assign ram_wr    = cmd.commit && sched_ok;
   assign ram_rd    = cmd.scan_read || cmd.fetch;
   assign ram_raddr = cmd.fetch ? best_ff : scan_idx_ff;
   assign rd_time   = ram_rdata[EW-1 -: teq_pkg::TIME_W];
   assign take      = scan_vld_ff && !dead_ff[rd_idx_ff] &&
                      (!found_ff || (rd_time < best_time_ff));

   teq_ram #(
      .WIDTH (EW),
      .DEPTH (teq_pkg::CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (used_ff[IDX_W-1:0]),
      .wr_data ({time_ff, handler_ff, payload_ff}),
      .rd_en   (ram_rd),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // result decode
   always_comb begin
      sched_ok  = 1'b0;
      cancel_ok = 1'b0;
      pop_ok    = 1'b0;
      status_in = teq_pkg::ST_IGNORED;
      slot_in   = '0;
      unique case (cmd_ff)
         teq_pkg::CMD_SCHEDULE: begin
            if (full) begin
               status_in = teq_pkg::ST_FULL;
            end else begin
               sched_ok  = 1'b1;
               status_in = teq_pkg::ST_DONE;
               slot_in   = teq_pkg::SLOT_W'(used_ff[IDX_W-1:0]);
            end
         end
         teq_pkg::CMD_CANCEL: begin
            if ({1'b0, token_ff} < teq_pkg::CMP_W'(used_ff)) begin
               cancel_ok = 1'b1;
               status_in = teq_pkg::ST_DONE;
               slot_in   = token_ff;
            end
         end
         teq_pkg::CMD_POP: begin
            if (found_ff) begin
               pop_ok    = 1'b1;
               status_in = teq_pkg::ST_DONE;
               slot_in   = teq_pkg::SLOT_W'(best_ff);
            end else begin
               status_in = teq_pkg::ST_EMPTY;
            end
         end
         default: begin
            status_in = teq_pkg::ST_IGNORED;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         dead_ff     <= '0;
         scan_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         scan_idx_ff <= '0;
      end else begin
         scan_vld_ff <= cmd.scan_read;
         if (cmd.latch) begin
            found_ff    <= 1'b0;
            scan_idx_ff <= '0;
         end
         if (cmd.scan_read) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         if (take) begin
            found_ff <= 1'b1;
         end
         if (cmd.commit) begin
            if (sched_ok) begin
               dead_ff[used_ff[IDX_W-1:0]] <= 1'b0;
               used_ff                     <= used_ff + 1'b1;
            end
            if (cancel_ok) begin
               dead_ff[token_ff[IDX_W-1:0]] <= 1'b1;
            end
            if (pop_ok) begin
               dead_ff[best_ff] <= 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff     <= req_command;
         time_ff    <= req_event_time;
         handler_ff <= req_handler_id;
         payload_ff <= req_payload;
         token_ff   <= req_token;
      end
      rd_idx_ff <= scan_idx_ff;
      if (take) begin
         best_ff      <= rd_idx_ff;
         best_time_ff <= rd_time;
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         if (pop_ok) begin
            fire_time_ff    <= rd_time;
            fire_handler_ff <= ram_rdata[teq_pkg::PAYLOAD_W +: teq_pkg::HANDLER_W];
            fire_payload_ff <= ram_rdata[teq_pkg::PAYLOAD_W-1:0];
         end else begin
            fire_time_ff    <= '0;
            fire_handler_ff <= '0;
            fire_payload_ff <= '0;
         end
      end
   end

   assign sts.command   = req_command;
   assign sts.used_zero = (used_ff == '0);
   assign sts.scan_last = ((CNT_W'(scan_idx_ff) + 1'b1) == used_ff);

   assign rsp_status       = status_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_fire_time    = fire_time_ff;
   assign rsp_fire_handler = fire_handler_ff;
   assign rsp_fire_payload = fire_payload_ff;

endmodule

// ===== dv/teq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_checker
// watches both channels of the timed event queue, predicts each result beat
// from its own copy of the event table and compares it field by field
// ----------------------------------------------------------------------------
module teq_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic [teq_pkg::TIME_W-1:0]    req_event_time,
   input  logic [teq_pkg::HANDLER_W-1:0] req_handler_id,
   input  logic [teq_pkg::PAYLOAD_W-1:0] req_payload,
   input  logic [teq_pkg::SLOT_W-1:0]    req_token,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [1:0]                    rsp_status,
   input  logic [teq_pkg::SLOT_W-1:0]    rsp_slot,
   input  logic [teq_pkg::TIME_W-1:0]    rsp_fire_time,
   input  logic [teq_pkg::HANDLER_W-1:0] rsp_fire_handler,
   input  logic [teq_pkg::PAYLOAD_W-1:0] rsp_fire_payload,
   output int                            fail_total,
   output int                            outstanding
);

   typedef struct packed {
      logic [1:0]                    status;
      logic [teq_pkg::SLOT_W-1:0]    slot;
      logic [teq_pkg::TIME_W-1:0]    fire_time;
      logic [teq_pkg::HANDLER_W-1:0] fire_handler;
      logic [teq_pkg::PAYLOAD_W-1:0] fire_payload;
   } teq_answer_type;

   // shadow event table
   logic [teq_pkg::TIME_W-1:0]    ev_time    [teq_pkg::CAPACITY];
   logic [teq_pkg::HANDLER_W-1:0] ev_handler [teq_pkg::CAPACITY];
   logic [teq_pkg::PAYLOAD_W-1:0] ev_payload [teq_pkg::CAPACITY];
   bit                            ev_dead    [teq_pkg::CAPACITY];
   int                            used_count;

   teq_answer_type                awaited_answers[$];

   initial begin
      fail_total  = 0;
      outstanding = 0;
      used_count  = 0;
   end

   // apply one command to the shadow table and work out its answer
   function automatic teq_answer_type apply_command(
      input logic [1:0]                    cmd,
      input logic [teq_pkg::TIME_W-1:0]    t,
      input logic [teq_pkg::HANDLER_W-1:0] h,
      input logic [teq_pkg::PAYLOAD_W-1:0] p,
      input logic [teq_pkg::SLOT_W-1:0]    tok);
      teq_answer_type ans;
      bit             found;
      int             best;
      int             i;
      ans   = '0;
      found = 1'b0;
      best  = 0;
      case (cmd)
         teq_pkg::CMD_SCHEDULE: begin
            if (used_count >= teq_pkg::CAPACITY) begin
               ans.status = teq_pkg::ST_FULL;
            end else begin
               ev_time[used_count]    = t;
               ev_handler[used_count] = h;
               ev_payload[used_count] = p;
               ev_dead[used_count]    = 1'b0;
               ans.status = teq_pkg::ST_DONE;
               ans.slot   = teq_pkg::SLOT_W'(used_count);
               used_count++;
            end
         end
         teq_pkg::CMD_CANCEL: begin
            if (int'(tok) < used_count) begin
               ev_dead[tok] = 1'b1;
               ans.status   = teq_pkg::ST_DONE;
               ans.slot     = tok;
            end else begin
               ans.status = teq_pkg::ST_IGNORED;
            end
         end
         teq_pkg::CMD_POP: begin
            // strict less-than keeps the lower slot on a tie
            for (i = 0; i < used_count; i++) begin
               if (!ev_dead[i] && (!found || ev_time[i] < ev_time[best])) begin
                  best  = i;
                  found = 1'b1;
               end
            end
            if (!found) begin
               ans.status = teq_pkg::ST_EMPTY;
            end else begin
               ev_dead[best]    = 1'b1;
               ans.status       = teq_pkg::ST_DONE;
               ans.slot         = teq_pkg::SLOT_W'(best);
               ans.fire_time    = ev_time[best];
               ans.fire_handler = ev_handler[best];
               ans.fire_payload = ev_payload[best];
            end
         end
         default: begin
            ans.status = teq_pkg::ST_IGNORED;
         end
      endcase
      return ans;
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         fail_total++;
         if (fail_total <= 10)
            $display("teq_checker: %0t %s expected %0h got %0h", $realtime, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      teq_answer_type want;
      teq_answer_type got;
      if (reset) begin
         used_count = 0;
         foreach (ev_dead[i]) ev_dead[i] = 1'b0;
         awaited_answers.delete();
      end else begin
         // compare before predicting so a stray beat never meets a fresh answer
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_slot, rsp_fire_time, rsp_fire_handler, rsp_fire_payload};
            if (awaited_answers.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("teq_checker: %0t result beat with none awaited", $realtime);
            end else begin
               want = awaited_answers.pop_front();
               note_mismatch("status", 64'(want.status), 64'(got.status));
               note_mismatch("slot", 64'(want.slot), 64'(got.slot));
               note_mismatch("fire_time", 64'(want.fire_time), 64'(got.fire_time));
               note_mismatch("fire_handler", 64'(want.fire_handler), 64'(got.fire_handler));
               note_mismatch("fire_payload", 64'(want.fire_payload), 64'(got.fire_payload));
            end
         end
         if (req_valid && !req_stall)
            awaited_answers.push_back(apply_command(req_command, req_event_time,
                                                    req_handler_id, req_payload, req_token));
      end
      outstanding = awaited_answers.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the timed event queue with a directed opening and a long random run
// of schedule, cancel and pop beats under varying idle and stall patterns;
// the checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb_top;

   // command code the block has no use for
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   localparam int RANDOM_ITEMS  = 1034;
   localparam int PRESSURE_AT   = 100;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 64;
   localparam int LIMIT_CYCLES  = 500000;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [1:0]                    req_command;
   logic [teq_pkg::TIME_W-1:0]    req_event_time;
   logic [teq_pkg::HANDLER_W-1:0] req_handler_id;
   logic [teq_pkg::PAYLOAD_W-1:0] req_payload;
   logic [teq_pkg::SLOT_W-1:0]    req_token;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [1:0]                    rsp_status;
   logic [teq_pkg::SLOT_W-1:0]    rsp_slot;
   logic [teq_pkg::TIME_W-1:0]    rsp_fire_time;
   logic [teq_pkg::HANDLER_W-1:0] rsp_fire_handler;
   logic [teq_pkg::PAYLOAD_W-1:0] rsp_fire_payload;

   int fail_total;
   int outstanding;

   // idling mix of the current phase, in percent
   int idle_pct;
   int stall_pct;
   // request for one long receiver hold-off, raised once by the stimulus
   bit hold_req;
   // schedule beats offered so far, used to aim cancel tokens at used slots
   int sched_sent;
   int cycle_count;

   timed_event_queue_with_cancel_top u_dut (.*);

   teq_checker u_checker (.*);

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit; generous against the slowest legal run
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   // receiver: random stall at each falling edge, or one long hold-off when asked
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            // counted here so the sender keeps offering beats meanwhile
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   function automatic logic [teq_pkg::PAYLOAD_W-1:0] rand_payload();
      return teq_pkg::PAYLOAD_W'({$urandom, $urandom});
   endfunction

   // half the times from a narrow window so ties between slots are common
   function automatic logic [teq_pkg::TIME_W-1:0] rand_event_time();
      if ($urandom_range(0, 1) != 0)
         return teq_pkg::TIME_W'($urandom_range(0, 15));
      return teq_pkg::TIME_W'($urandom);
   endfunction

   // offer one request beat; entered and left just after a falling edge
   task automatic offer(input logic [1:0]                    cmd,
                        input logic [teq_pkg::TIME_W-1:0]    t,
                        input logic [teq_pkg::HANDLER_W-1:0] h,
                        input logic [teq_pkg::PAYLOAD_W-1:0] p,
                        input logic [teq_pkg::SLOT_W-1:0]    tok);
      // sender gaps; the payload is left alone while valid is low
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_event_time <= t;
      req_handler_id <= h;
      req_payload    <= p;
      req_token      <= tok;
      // hold the beat until the block takes it
      do @(posedge clock); while (req_stall);
      if (cmd == teq_pkg::CMD_SCHEDULE)
         sched_sent++;
      @(negedge clock);
   endtask

   task automatic offer_schedule(input logic [teq_pkg::TIME_W-1:0]    t,
                                 input logic [teq_pkg::HANDLER_W-1:0] h,
                                 input logic [teq_pkg::PAYLOAD_W-1:0] p);
      offer(teq_pkg::CMD_SCHEDULE, t, h, p, teq_pkg::SLOT_W'($urandom));
   endtask

   task automatic offer_cancel(input logic [teq_pkg::SLOT_W-1:0] tok);
      offer(teq_pkg::CMD_CANCEL, rand_event_time(), teq_pkg::HANDLER_W'($urandom),
            rand_payload(), tok);
   endtask

   task automatic offer_pop();
      offer(teq_pkg::CMD_POP, rand_event_time(), teq_pkg::HANDLER_W'($urandom),
            rand_payload(), teq_pkg::SLOT_W'($urandom));
   endtask

   initial begin
      int n;
      int pick;
      int burst;
      int used_bound;
      bit pressure_done;

      // every input known from the start
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = teq_pkg::CMD_SCHEDULE;
      req_event_time = '0;
      req_handler_id = '0;
      req_payload    = '0;
      req_token      = '0;
      idle_pct       = 0;
      stall_pct      = 0;
      hold_req       = 1'b0;
      sched_sent     = 0;
      pressure_done  = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---------------- directed opening ----------------
      // empty queue pop, token beyond used slots and the unused code on a fresh table
      offer_pop();
      offer_cancel(8'd0);
      offer(CMD_UNUSED, '1, '1, '1, '1);
      // extremes of every scheduled field
      offer_schedule('1, '1, '1);
      offer_schedule('0, '0, '0);
      // two equal times: the lower slot has to win
      offer_schedule(teq_pkg::TIME_W'(5), 8'hA5, rand_payload());
      offer_schedule(teq_pkg::TIME_W'(5), 8'h5A, rand_payload());
      // successful cancel, then a cancel of the now dead slot
      offer_cancel(8'd1);
      offer_cancel(8'd1);
      // token far out and token just past the last used slot
      offer_cancel(8'hFF);
      offer_cancel(8'd4);
      // tie resolution, then the latest time, then nothing left
      offer_pop();
      offer_pop();
      offer_pop();
      offer_pop();
      // cancel of a slot already taken by a pop
      offer_cancel(8'd3);

      // ---------------- random run ----------------
      // quarters: no idling, sender idle, receiver stalls, both a little
      n = 0;
      while (n < RANDOM_ITEMS) begin
         case (n * 4 / RANDOM_ITEMS)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 64; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 64; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase

         // long receiver hold-off while beats keep coming, so the block backs up
         if (!pressure_done && n >= PRESSURE_AT) begin
            hold_req      = 1'b1;
            pressure_done = 1'b1;
         end

         used_bound = (sched_sent < teq_pkg::CAPACITY) ? sched_sent : teq_pkg::CAPACITY;
         pick       = $urandom_range(0, 999);
         if (pick < 15) begin
            // short burst of schedules; the table fills over the run and stays full
            burst = $urandom_range(1, 5);
            repeat (burst) begin
               offer_schedule(rand_event_time(), teq_pkg::HANDLER_W'($urandom),
                              rand_payload());
               n++;
            end
         end else if (pick < 300) begin
            offer_pop();
            n++;
         end else if (pick < 960) begin
            // mostly tokens in or just past the used range, some anywhere
            if ($urandom_range(0, 4) != 0)
               offer_cancel(teq_pkg::SLOT_W'($urandom_range(0, used_bound)));
            else
               offer_cancel(teq_pkg::SLOT_W'($urandom_range(0, 255)));
            n++;
         end else begin
            offer(CMD_UNUSED, rand_event_time(), teq_pkg::HANDLER_W'($urandom),
                  rand_payload(), teq_pkg::SLOT_W'($urandom));
            n++;
         end
      end

      // ---------------- wind-down ----------------
      req_valid <= 1'b0;
      stall_pct = 0;
      while (outstanding != 0) @(negedge clock);
      // catch any stray beat after the last awaited one
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_total == 0 && outstanding == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ===== timed_event_queue_with_cancel_top.f =====
src/teq_pkg.sv
src/teq_ram.sv
src/teq_ctrl.sv
src/teq_dp.sv
src/timed_event_queue_with_cancel_top.sv
dv/teq_checker.sv
dv/tb_top.sv
